// ----- rtl/a32c_pkg.sv -----
package a32c_pkg;

  localparam int unsigned NumEntries = 108;
  localparam int unsigned IdxW       = 7;
  localparam int unsigned NumGroups  = 4;
  localparam int unsigned GroupSize  = 27;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_BRANCH = 3'd1,
    KIND_BLX    = 3'd2,
    KIND_WORD   = 3'd3,
    KIND_HALF   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] pattern;
    kind_e       kind;
  } entry_t;

  // per-group first-hit summary, handed from match stage to merge stage
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } grp_hit_t;

  // insn sits in the low half, as on the input bus
  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] insn;
  } item_t;

  function automatic entry_t ent(logic [31:0] m, logic [31:0] p, kind_e k);
    entry_t e;
    e.mask = m;
    e.pattern = p;
    e.kind = k;
    return e;
  endfunction

  function automatic entry_t entry_at(logic [IdxW-1:0] i);
    entry_t e;
    unique case (i)
      7'd0:   e = ent(32'h0fffffff, 32'h0ff00000, KIND_NONE);
      7'd1:   e = ent(32'h0fffffff, 32'h0ff00001, KIND_NONE);
      7'd2:   e = ent(32'h0f000000, 32'h0f000000, KIND_NONE);
      7'd3:   e = ent(32'hfe000000, 32'hfa000000, KIND_BLX);
      7'd4:   e = ent(32'h0f000000, 32'h0a000000, KIND_BRANCH);
      7'd5:   e = ent(32'h0f000000, 32'h0b000000, KIND_BRANCH);
      7'd6:   e = ent(32'h0fe000f0, 32'h00000090, KIND_NONE);
      7'd7:   e = ent(32'h0fe000f0, 32'h00200090, KIND_NONE);
      7'd8:   e = ent(32'h0fe000f0, 32'h00800090, KIND_NONE);
      7'd9:   e = ent(32'h0fe000f0, 32'h00c00090, KIND_NONE);
      7'd10:  e = ent(32'h0fe000f0, 32'h00a00090, KIND_NONE);
      7'd11:  e = ent(32'h0fe000f0, 32'h00e00090, KIND_NONE);
      7'd12:  e = ent(32'h0d700000, 32'h04200000, KIND_WORD);
      7'd13:  e = ent(32'h0d700000, 32'h04300000, KIND_WORD);
      7'd14:  e = ent(32'h0d700000, 32'h04600000, KIND_WORD);
      7'd15:  e = ent(32'h0d700000, 32'h04700000, KIND_WORD);
      7'd16:  e = ent(32'h0c500000, 32'h04000000, KIND_WORD);
      7'd17:  e = ent(32'h0c500000, 32'h04100000, KIND_WORD);
      7'd18:  e = ent(32'h0c500000, 32'h04400000, KIND_WORD);
      7'd19:  e = ent(32'h0c500000, 32'h04500000, KIND_WORD);
      7'd20:  e = ent(32'h0e1f0000, 32'h080d0000, KIND_NONE);
      7'd21:  e = ent(32'h0e1f0000, 32'h081d0000, KIND_NONE);
      7'd22:  e = ent(32'h0e100000, 32'h08000000, KIND_NONE);
      7'd23:  e = ent(32'h0e100000, 32'h08100000, KIND_NONE);
      7'd24:  e = ent(32'h0e1000f0, 32'h00100090, KIND_HALF);
      7'd25:  e = ent(32'h0e1000f0, 32'h00000090, KIND_HALF);
      7'd26:  e = ent(32'h0e1000f0, 32'h001000d0, KIND_HALF);
      7'd27:  e = ent(32'h0e1000f0, 32'h001000b0, KIND_HALF);
      7'd28:  e = ent(32'h0e1000f0, 32'h000000b0, KIND_HALF);
      7'd29:  e = ent(32'h0e1000f0, 32'h001000f0, KIND_HALF);
      7'd30:  e = ent(32'h0f200090, 32'h00200090, KIND_NONE);
      7'd31:  e = ent(32'h0e1000d0, 32'h000000d0, KIND_NONE);
      7'd32:  e = ent(32'h0ff00ff0, 32'h01000090, KIND_NONE);
      7'd33:  e = ent(32'h0ff00ff0, 32'h01400090, KIND_NONE);
      7'd34:  e = ent(32'h0fbf0fff, 32'h010f0000, KIND_NONE);
      7'd35:  e = ent(32'h0fb0fff0, 32'h0120f000, KIND_NONE);
      7'd36:  e = ent(32'h0fb0f000, 32'h0320f000, KIND_NONE);
      7'd37:  e = ent(32'h0ffffff0, 32'h012fff10, KIND_NONE);
      7'd38:  e = ent(32'h0fff0ff0, 32'h016f0f10, KIND_NONE);
      7'd39:  e = ent(32'h0ffffff0, 32'h012fff30, KIND_NONE);
      7'd40:  e = ent(32'hfff000f0, 32'he1200070, KIND_NONE);
      7'd41:  e = ent(32'h0de00000, 32'h00000000, KIND_NONE);
      7'd42:  e = ent(32'h0de00000, 32'h00200000, KIND_NONE);
      7'd43:  e = ent(32'h0de00000, 32'h00400000, KIND_NONE);
      7'd44:  e = ent(32'h0de00000, 32'h00600000, KIND_NONE);
      7'd45:  e = ent(32'h0de00000, 32'h00800000, KIND_NONE);
      7'd46:  e = ent(32'h0de00000, 32'h00a00000, KIND_NONE);
      7'd47:  e = ent(32'h0de00000, 32'h00c00000, KIND_NONE);
      7'd48:  e = ent(32'h0de00000, 32'h00e00000, KIND_NONE);
      7'd49:  e = ent(32'h0df00000, 32'h01100000, KIND_NONE);
      7'd50:  e = ent(32'h0df00000, 32'h01300000, KIND_NONE);
      7'd51:  e = ent(32'h0de00000, 32'h01400000, KIND_NONE);
      7'd52:  e = ent(32'h0de00000, 32'h01600000, KIND_NONE);
      7'd53:  e = ent(32'h0de00000, 32'h01800000, KIND_NONE);
      7'd54:  e = ent(32'h0de00000, 32'h01a00000, KIND_NONE);
      7'd55:  e = ent(32'h0de00000, 32'h01c00000, KIND_NONE);
      7'd56:  e = ent(32'h0de00000, 32'h01e00000, KIND_NONE);
      7'd57:  e = ent(32'h0ff08f10, 32'h0e000100, KIND_NONE);
      7'd58:  e = ent(32'h0ff08f10, 32'h0e100100, KIND_NONE);
      7'd59:  e = ent(32'h0ff08f10, 32'h0e200100, KIND_NONE);
      7'd60:  e = ent(32'h0ff08f10, 32'h0e300100, KIND_NONE);
      7'd61:  e = ent(32'h0ff08f10, 32'h0e400100, KIND_NONE);
      7'd62:  e = ent(32'h0ff08f10, 32'h0e500100, KIND_NONE);
      7'd63:  e = ent(32'h0ff08f10, 32'h0e600100, KIND_NONE);
      7'd64:  e = ent(32'h0ff08f10, 32'h0e700100, KIND_NONE);
      7'd65:  e = ent(32'h0ff08f10, 32'h0e800100, KIND_NONE);
      7'd66:  e = ent(32'h0ff08f10, 32'h0e900100, KIND_NONE);
      7'd67:  e = ent(32'h0ff08f10, 32'h0ea00100, KIND_NONE);
      7'd68:  e = ent(32'h0ff08f10, 32'h0eb00100, KIND_NONE);
      7'd69:  e = ent(32'h0ff08f10, 32'h0ec00100, KIND_NONE);
      7'd70:  e = ent(32'h0f008f10, 32'h0e000100, KIND_NONE);
      7'd71:  e = ent(32'h0ff08f10, 32'h0e008100, KIND_NONE);
      7'd72:  e = ent(32'h0ff08f10, 32'h0e108100, KIND_NONE);
      7'd73:  e = ent(32'h0ff08f10, 32'h0e208100, KIND_NONE);
      7'd74:  e = ent(32'h0ff08f10, 32'h0e308100, KIND_NONE);
      7'd75:  e = ent(32'h0ff08f10, 32'h0e408100, KIND_NONE);
      7'd76:  e = ent(32'h0ff08f10, 32'h0e508100, KIND_NONE);
      7'd77:  e = ent(32'h0ff08f10, 32'h0e608100, KIND_NONE);
      7'd78:  e = ent(32'h0ff08f10, 32'h0e708100, KIND_NONE);
      7'd79:  e = ent(32'h0ff08f10, 32'h0e808100, KIND_NONE);
      7'd80:  e = ent(32'h0ff08f10, 32'h0e908100, KIND_NONE);
      7'd81:  e = ent(32'h0ff08f10, 32'h0ea08100, KIND_NONE);
      7'd82:  e = ent(32'h0ff08f10, 32'h0eb08100, KIND_NONE);
      7'd83:  e = ent(32'h0ff08f10, 32'h0ec08100, KIND_NONE);
      7'd84:  e = ent(32'h0ff08f10, 32'h0ed08100, KIND_NONE);
      7'd85:  e = ent(32'h0f008f10, 32'h0e008100, KIND_NONE);
      7'd86:  e = ent(32'h0e100f00, 32'h0c000100, KIND_NONE);
      7'd87:  e = ent(32'h0e100f00, 32'h0c100100, KIND_NONE);
      7'd88:  e = ent(32'h0ff00f10, 32'h0e000110, KIND_NONE);
      7'd89:  e = ent(32'h0ff00f10, 32'h0e100110, KIND_NONE);
      7'd90:  e = ent(32'h0ff00f10, 32'h0e200110, KIND_NONE);
      7'd91:  e = ent(32'h0ff00f10, 32'h0e300110, KIND_NONE);
      7'd92:  e = ent(32'h0ff00f10, 32'h0e400110, KIND_NONE);
      7'd93:  e = ent(32'h0ff00f10, 32'h0e500110, KIND_NONE);
      7'd94:  e = ent(32'h0ff0ff10, 32'h0e90f110, KIND_NONE);
      7'd95:  e = ent(32'h0ff0ff10, 32'h0eb0f110, KIND_NONE);
      7'd96:  e = ent(32'h0ff0ff10, 32'h0ed0f110, KIND_NONE);
      7'd97:  e = ent(32'h0ff0ff10, 32'h0ef0f110, KIND_NONE);
      7'd98:  e = ent(32'hff100010, 32'hfe000010, KIND_NONE);
      7'd99:  e = ent(32'h0f100010, 32'h0e000010, KIND_NONE);
      7'd100: e = ent(32'hff100010, 32'hfe100010, KIND_NONE);
      7'd101: e = ent(32'h0f100010, 32'h0e100010, KIND_NONE);
      7'd102: e = ent(32'hff000010, 32'hfe000000, KIND_NONE);
      7'd103: e = ent(32'h0f000010, 32'h0e000000, KIND_NONE);
      7'd104: e = ent(32'hfe100090, 32'hfc100000, KIND_NONE);
      7'd105: e = ent(32'h0e100090, 32'h0c100000, KIND_NONE);
      7'd106: e = ent(32'hfe100090, 32'hfc000000, KIND_NONE);
      7'd107: e = ent(32'h0e100090, 32'h0c000000, KIND_NONE);
      // unused slots never match: pattern has bits outside the mask
      default: e = ent(32'h00000000, 32'h00000001, KIND_NONE);
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/a32c_match.sv -----
// Stage 1: compare against all table entries, first hit per group of 27.
module a32c_match (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [31:0]                             insn_i,
  output a32c_pkg::grp_hit_t [a32c_pkg::NumGroups-1:0] grp_o
);
  import a32c_pkg::*;

  grp_hit_t [NumGroups-1:0] grp_d, grp_q;

  always_comb begin
    entry_t e;
    logic [IdxW-1:0] k;
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int j = GroupSize - 1; j >= 0; j--) begin
        k = IdxW'(g * GroupSize + j);
        e = entry_at(k);
        if ((insn_i & e.mask) == e.pattern) begin
          grp_d[g].hit = 1'b1;
          grp_d[g].idx = k;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

// ----- rtl/a32c_target.sv -----
// Stage 2 and 3: merge group hits, then compute immediate and target.
module a32c_target (
  input  logic                                         clk_i,
  input  logic                                         en2_i,
  input  logic                                         en3_i,
  input  a32c_pkg::grp_hit_t [a32c_pkg::NumGroups-1:0] grp_i,
  input  a32c_pkg::item_t                              item_i,
  output logic                                         matched_o,
  output logic [a32c_pkg::IdxW-1:0]                    idx_o,
  output logic                                         shown_o,
  output logic [31:0]                                  imm_o,
  output logic [31:0]                                  target_o,
  output logic                                         tvalid_o
);
  import a32c_pkg::*;

  logic            hit_d, hit_q;
  logic [IdxW-1:0] idx_d, idx_q;

  always_comb begin
    hit_d = 1'b0;
    idx_d = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (grp_i[g].hit) begin
        hit_d = 1'b1;
        idx_d = grp_i[g].idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      hit_q <= hit_d;
      idx_q <= idx_d;
    end
  end

  entry_t      e;
  logic [31:0] insn, pc, boff, loff, imm_d, tgt_d;
  logic [7:0]  imm_byte;
  logic [4:0]  rot;
  logic        tv_d, sh_d;

  assign insn = item_i.insn;
  assign pc   = item_i.pc;
  assign e    = entry_at(idx_q);
  assign imm_byte = insn[7:0];
  assign rot  = {insn[11:8], 1'b0};

  always_comb begin
    imm_d = '0;
    if (insn[25]) begin
      imm_d = ({24'd0, imm_byte} >> rot) | ({24'd0, imm_byte} << (6'd32 - {1'b0, rot}));
      if (rot == 5'd0) imm_d = {24'd0, imm_byte};
    end
    boff = {{6{insn[23]}}, insn[23:0], 2'b00};
    if (e.kind == KIND_BLX) boff[1] = insn[24];
    loff = (e.kind == KIND_HALF) ? {24'd0, insn[11:8], insn[3:0]} : {20'd0, insn[11:0]};
    tv_d  = 1'b0;
    tgt_d = '0;
    sh_d  = hit_q && (e.mask[31:28] != 4'hf);
    if (hit_q) begin
      case (e.kind)
        KIND_BRANCH, KIND_BLX: begin
          tv_d = 1'b1;
          tgt_d = pc + 32'd8 + boff;
        end
        KIND_WORD: begin
          if ((insn & 32'h032f0000) == 32'h010f0000) begin
            tv_d = 1'b1;
            tgt_d = (insn[23] ? pc + loff : pc - loff) + 32'd8;
          end
        end
        KIND_HALF: begin
          if ((insn & 32'h004f0000) == 32'h004f0000) begin
            tv_d = 1'b1;
            tgt_d = (insn[23] ? pc + loff : pc - loff) + 32'd8;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      matched_o <= hit_q;
      idx_o     <= hit_q ? idx_q : '0;
      shown_o   <= sh_d;
      imm_o     <= imm_d;
      target_o  <= tgt_d;
      tvalid_o  <= tv_d;
    end
  end

endmodule

// ----- rtl/arm32_instruction_classifier.sv -----
// Channel | Dir | tdata (low bit first)                               | tuser
// s_axis  | in  | insn[31:0], pc[63:32]                                | -
// m_axis  | out | matched, entry_index[7:1], cond_code[11:8],         | -
//         |     | cond_shown[12], dest_reg, base_reg, shift_reg,      |
//         |     | low_reg [28:13], immediate[60:29], target[92:61],    |
//         |     | target_valid[93], zero pad to 96                     |
// One item per cycle is sustained while m_axis_tready stays high.
// Stage 1 matches the 108-entry table in four groups, stage 2 merges the
// group hits, stage 3 forms the immediate and the 32-bit target add.
// Reset clears the stage valid bits only.
// A stalled output holds each full stage back to the first empty one.
module arm32_instruction_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // insn, pc
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // see table above
);
  import a32c_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  item_t it1_q, it2_q, it3_q;
  grp_hit_t [NumGroups-1:0] grp;
  logic            matched, shown, tvalid;
  logic [IdxW-1:0] idx;
  logic [31:0]     imm, tgt;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) it1_q <= s_axis_tdata;
    if (en2) it2_q <= it1_q;
    if (en3) it3_q <= it2_q;
  end

  a32c_match u_match (
    .clk_i  (clk_i),
    .en_i   (en1),
    .insn_i (s_axis_tdata[31:0]),
    .grp_o  (grp)
  );

  a32c_target u_target (
    .clk_i     (clk_i),
    .en2_i     (en2),
    .en3_i     (en3),
    .grp_i     (grp),
    .item_i    (it2_q),
    .matched_o (matched),
    .idx_o     (idx),
    .shown_o   (shown),
    .imm_o     (imm),
    .target_o  (tgt),
    .tvalid_o  (tvalid)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata = {2'b00, tvalid, tgt, imm, it3_q.insn[3:0], it3_q.insn[11:8],
                         it3_q.insn[19:16], it3_q.insn[15:12], shown,
                         it3_q.insn[31:28], idx, matched};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_tv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tvalid |-> matched)
    else $error("target without match");
  a_sh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !matched |-> !shown && idx == '0 && tgt == '0)
    else $error("unmatched item carries entry data");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en2 |=> v2_q)
    else $error("stage 2 item lost");

endmodule
